@@ hdl/swsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsm_pkg
// Shared widths, constants and the queue item type of the sliding window
// sum tracker.
// ----------------------------------------------------------------------------
package swsm_pkg;

    localparam int MAX_WINDOW  = 1024;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int SAMPLE_W    = 16;
    localparam int WIN_W       = 11;
    localparam int SUM_W       = 26;
    localparam int OUT_DATA_W  = 56;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);
    localparam logic [SUM_W-1:0] SUM_ONES  = {SUM_W{1'b1}};

    // One classified request handed from the front part to the back part.
    typedef struct packed {
        logic [SUM_W-1:0] sum;      // window sum including the current sample
        logic             full;     // a complete window stands behind this sum
        logic             last;     // final request of the run
    } swsm_item_t;

endpackage : swsm_pkg
`default_nettype wire

@@ hdl/swsm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsm_front
// Intake: sample ring, fill tracking and running window sum.
// ----------------------------------------------------------------------------
module swsm_front
    import swsm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [WIN_W-1:0]    cfg_wdata,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] in_sample,
    input  wire logic                in_last,
    output logic                     push,
    output swsm_item_t               push_item,
    input  wire logic                q_full
);

    logic [SAMPLE_W-1:0] ring_mem [MAX_WINDOW];

    logic [WIN_W-1:0]    win_reg;
    logic [PTR_W-1:0]    wp_reg;
    logic [WIN_W-1:0]    fill_reg;
    logic [SUM_W-1:0]    run_reg, run_next;
    logic                a_valid_reg;
    logic [SAMPLE_W-1:0] a_sample_reg;
    logic [SAMPLE_W-1:0] a_old_reg;
    logic                a_last_reg;
    logic                a_full_reg;
    logic                a_self_reg;

    logic [WIN_W-1:0]    eff_w;
    logic [WIN_W-1:0]    fill_inc;
    logic [PTR_W-1:0]    rd_addr;
    logic                acc;
    logic [SUM_W-1:0]    sum_w;
    logic [SAMPLE_W-1:0] old_sample;

    always_comb
    begin
        if (win_reg == '0)
        begin
            eff_w = WIN_W'(1);
        end
        else if (win_reg > WIN_MAX)
        begin
            eff_w = WIN_MAX;
        end
        else
        begin
            eff_w = win_reg;
        end
        fill_inc = (fill_reg < eff_w) ? fill_reg + WIN_W'(1) : fill_reg;
        // oldest sample of the window, w-1 places behind the write slot
        rd_addr  = wp_reg - PTR_W'(eff_w - WIN_W'(1));
        push     = a_valid_reg && !q_full;
        in_ready = !a_valid_reg || push;
        acc      = in_valid && in_ready;

        sum_w      = run_reg + SUM_W'(a_sample_reg);
        old_sample = a_self_reg ? a_sample_reg : a_old_reg;
        if (a_last_reg)
        begin
            run_next = '0;
        end
        else if (a_full_reg)
        begin
            run_next = sum_w - SUM_W'(old_sample);
        end
        else
        begin
            run_next = sum_w;
        end
        push_item.sum  = sum_w;
        push_item.full = a_full_reg;
        push_item.last = a_last_reg;
    end

    // Ring: write the new sample and read the oldest one at the same edge.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ring_mem[wp_reg] <= in_sample;
            a_old_reg        <= ring_mem[rd_addr];
            a_sample_reg     <= in_sample;
            a_last_reg       <= in_last;
            a_full_reg       <= (fill_inc >= eff_w);
            a_self_reg       <= (eff_w == WIN_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= WIN_RESET;
            wp_reg      <= '0;
            fill_reg    <= '0;
            run_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            win_reg  <= cfg_wdata;
            wp_reg   <= '0;
            fill_reg <= '0;
            run_reg  <= '0;
        end
        else
        begin
            if (acc)
            begin
                wp_reg   <= in_last ? '0 : wp_reg + PTR_W'(1);
                fill_reg <= in_last ? '0 : fill_inc;
            end
            if (push)
            begin
                run_reg <= run_next;
            end
            if (acc)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                a_valid_reg <= 1'b0;
            end
        end
    end

endmodule : swsm_front
`default_nettype wire

@@ hdl/swsm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsm_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module swsm_queue
    import swsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire swsm_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            q_valid,
    output swsm_item_t      q_item
);

    swsm_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule : swsm_queue
`default_nettype wire

@@ hdl/swsm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsm_back
// Minimum and maximum tracking and the output register.
// ----------------------------------------------------------------------------
module swsm_back
    import swsm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              q_valid,
    input  wire swsm_item_t        q_item,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_full,
    output logic [SUM_W-1:0]       out_min,
    output logic [SUM_W-1:0]       out_max,
    output logic                   out_last
);

    logic [SUM_W-1:0] lowest_reg, lowest_next;
    logic [SUM_W-1:0] highest_reg, highest_next;
    logic             out_valid_reg;
    logic             out_full_reg;
    logic [SUM_W-1:0] out_min_reg;
    logic [SUM_W-1:0] out_max_reg;
    logic             out_last_reg;

    always_comb
    begin
        pop          = q_valid && (!out_valid_reg || out_ready);
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        if (q_item.full)
        begin
            if (q_item.sum < lowest_reg)
            begin
                lowest_next = q_item.sum;
            end
            if (q_item.sum > highest_reg)
            begin
                highest_next = q_item.sum;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_full  = out_full_reg;
    assign out_min   = out_min_reg;
    assign out_max   = out_max_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_full_reg <= q_item.full;
            out_min_reg  <= q_item.full ? lowest_next : '0;
            out_max_reg  <= q_item.full ? highest_next : '0;
            out_last_reg <= q_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg    <= SUM_ONES;
            highest_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            lowest_reg  <= SUM_ONES;
            highest_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                // drop the run's extremes after its final request
                lowest_reg  <= q_item.last ? SUM_ONES : lowest_next;
                highest_reg <= q_item.last ? '0 : highest_next;
            end
        end
    end

endmodule : swsm_back
`default_nettype wire

@@ hdl/sliding_window_sum_min_max.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_sum_min_max
// Sliding window sum over a sample stream, with the smallest and largest
// full-window sums of the current run.
// ----------------------------------------------------------------------------
//  Channel  | Signals                         | Contents
//  ---------+---------------------------------+-------------------------------
//  s_axis   | tvalid tready tdata[15:0] tlast | sample, last
//  m_axis   | tvalid tready tdata[55:0] tuser | min_sum, max_sum, window_ready,
//           | tlast                           | end_of_run
//  cfg      | cfg_we cfg_wdata[10:0]          | window_size, write clears run
//
// One request per clock sustained while m_axis_tready stays high. A request
// passes the intake register, then the queue, then the output register
// before m_axis valid rises. The ring is a 1024 x 16 single-write,
// single-read memory read once per request. Reset is immediate, with no
// clearing pass: the ring only serves entries written in the current run.
// m_axis backpressure fills the two-entry queue and then the intake stage
// before s_axis_tready drops; no combinational path runs from m_axis_tready
// to s_axis_tready.
// ----------------------------------------------------------------------------
module sliding_window_sum_min_max
    import swsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic [WIN_W-1:0]      cfg_wdata,      // window_size
    // sample stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    input  wire logic                  s_axis_tlast,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [25:0] min_sum, [51:26] max_sum
    output logic                       m_axis_tuser,   // [0] window_ready
    output logic                       m_axis_tlast    // end_of_run
);

    logic             push;
    swsm_item_t       push_item;
    logic             q_full;
    logic             q_valid;
    swsm_item_t       q_item;
    logic             pop;
    logic [SUM_W-1:0] out_min;
    logic [SUM_W-1:0] out_max;

    // Front: write the ring, fetch the oldest sample, advance the running sum.
    swsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // Queue: decouple the sum path from output backpressure.
    swsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Back: fold each full-window sum into the run extremes and present them.
    swsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_full  (m_axis_tuser),
        .out_min   (out_min),
        .out_max   (out_max),
        .out_last  (m_axis_tlast)
    );

    // Pack the sums, low field first, padded up to whole bytes.
    assign m_axis_tdata = {(OUT_DATA_W - 2*SUM_W)'(0), out_max, out_min};

endmodule : sliding_window_sum_min_max
`default_nettype wire

@@ hdl/swsm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsm_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module swsm_checker
    import swsm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tuser,
    input  wire logic                  m_axis_tlast
);

    // Before a full window exists, both sums read as zero.
    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("sums not zero before a full window");

    // The run minimum never exceeds the run maximum.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[SUM_W-1:0] <= m_axis_tdata[2*SUM_W-1:SUM_W]))
        else $error("min_sum above max_sum");

    // A stalled result holds.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule : swsm_checker

bind sliding_window_sum_min_max swsm_checker u_swsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ tb/tb_sliding_window_sum_min_max.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_sum_min_max
// Streams sample runs through the sliding window sum tracker under several
// window lengths and random idling on both streams. Every result is checked
// field by field against an in-bench window model, or against values typed
// into the directed table.
// ----------------------------------------------------------------------------
module tb_sliding_window_sum_min_max;
    import swsm_pkg::*;

    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 8;

    // Result as the checker sees it.
    typedef struct packed {
        logic             ready;
        logic [SUM_W-1:0] lo;
        logic [SUM_W-1:0] hi;
        logic             eor;
    } stats_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_KNOWN, ROW_CFG} row_kind_t;

    // ROW_CFG rows carry the window length in value.
    // ROW_KNOWN rows carry the result in ready/lo/hi (end_of_run follows last).
    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
        logic                last;
        logic                ready;
        logic [SUM_W-1:0]    lo;
        logic [SUM_W-1:0]    hi;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 25;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // window of one after reset: each sample is its own window
        '{ROW_KNOWN,  16'hFFFF, 1'b0, 1'b1, 26'd65535, 26'd65535},
        '{ROW_KNOWN,  16'h0000, 1'b0, 1'b1, 26'd0,     26'd65535},
        '{ROW_KNOWN,  16'h00FF, 1'b1, 1'b1, 26'd0,     26'd65535},
        // run state cleared by last
        '{ROW_KNOWN,  16'h0001, 1'b0, 1'b1, 26'd1,     26'd1},
        '{ROW_KNOWN,  16'h8000, 1'b1, 1'b1, 26'd1,     26'd32768},
        // window of three: not ready for the first two samples
        '{ROW_CFG,    16'd3,    1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd10,   1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd20,   1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd30,   1'b0, 1'b1, 26'd60,    26'd60},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd7,    1'b1, 1'b0, 26'd0,     26'd0},
        // window length zero behaves as one
        '{ROW_CFG,    16'd0,    1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'hAAAA, 1'b0, 1'b1, 26'd43690, 26'd43690},
        '{ROW_KNOWN,  16'h5555, 1'b1, 1'b1, 26'd21845, 26'd43690},
        // oversize window length saturates, so a short run never fills it
        '{ROW_CFG,    16'd2047, 1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'hFFFF, 1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'h0000, 1'b1, 1'b0, 26'd0,     26'd0},
        // register write in the middle of a run clears it
        '{ROW_CFG,    16'd2,    1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd100,  1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd200,  1'b0, 1'b1, 26'd300,   26'd300},
        '{ROW_CFG,    16'd2,    1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd50,   1'b0, 1'b0, 26'd0,     26'd0},
        '{ROW_KNOWN,  16'd60,   1'b1, 1'b1, 26'd110,   26'd110}
    };

    // Random phases: window register value and number of requests.
    // Windows over 64 samples run as one long run, which fills only in the 2047 phase.
    localparam int NUM_PHASES     = 10;
    localparam int PRESSURE_PHASE = 7;
    localparam int PHASE_WIN   [NUM_PHASES] = '{0, 2, 3, 2047, 1024, 1025, 5, 17, 1, 64};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{40, 60, 60, 1060, 30, 30, 60, 100, 60, 80};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [WIN_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    // window model state
    logic [WIN_W-1:0]      win_reg;
    logic [SAMPLE_W-1:0]   sample_history [MAX_WINDOW];
    logic [PTR_W-1:0]      wr_ptr;
    logic [WIN_W-1:0]      fill_cnt;
    logic [SUM_W-1:0]      run_sum;
    logic [SUM_W-1:0]      low_sum;
    logic [SUM_W-1:0]      high_sum;

    stats_t                expected_stats [$];
    int                    error_count = 0;
    int                    cycle_count = 0;
    bit                    burst_mode  = 1'b0;
    bit                    rx_hold_req = 1'b0;

    sliding_window_sum_min_max u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // [15:0] sample
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // [25:0] min_sum, [51:26] max_sum, [55:52] zero
        .m_axis_tuser  (m_axis_tuser),     // [0] window_ready
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Clear the run state: pointer, fill level, running sum and extremes.
    function automatic void restart_run();
        wr_ptr   = '0;
        fill_cnt = '0;
        run_sum  = '0;
        low_sum  = SUM_ONES;
        high_sum = '0;
    endfunction

    // Advance the window model by one sample and return the result it yields.
    function automatic stats_t window_stats_step(input logic [SAMPLE_W-1:0] smp,
                                                 input logic lst);
        logic [WIN_W-1:0] span_len;
        logic [PTR_W-1:0] oldest;
        stats_t           res;
        span_len = (win_reg == '0) ? WIN_W'(1) : ((win_reg > WIN_MAX) ? WIN_MAX : win_reg);
        sample_history[wr_ptr] = smp;
        run_sum = run_sum + SUM_W'(smp);
        if (fill_cnt < span_len)
            fill_cnt = fill_cnt + 1'b1;
        res     = '0;
        res.eor = lst;
        if (fill_cnt >= span_len)
        begin
            // oldest sample of the window drops out after this sum is used
            oldest = wr_ptr - PTR_W'(span_len - 1'b1);
            if (run_sum < low_sum)
                low_sum = run_sum;
            if (run_sum > high_sum)
                high_sum = run_sum;
            res.ready = 1'b1;
            res.lo    = low_sum;
            res.hi    = high_sum;
            run_sum   = run_sum - SUM_W'(sample_history[oldest]);
        end
        wr_ptr = wr_ptr + 1'b1;
        if (lst)
            restart_run();
        return res;
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Offer one sample request; on acceptance record what it must produce.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                               input bit use_known, input stats_t known);
        int     gap;
        stats_t pred;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = window_stats_step(smp, lst);
        expected_stats.push_back(use_known ? known : pred);
    endtask

    // Write the window register once every pending result is back.
    task automatic write_window(input logic [WIN_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we  <= 1'b0;
        win_reg  = value;
        restart_run();
    endtask

    // Stimulus: reset, directed table, then random phases.
    initial
    begin : stimulus
        stim_row_t           row;
        stats_t              known;
        logic [SAMPLE_W-1:0] smp;
        int                  left;
        int                  seq_len;
        int                  weff;
        int                  r;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        win_reg        = WIN_RESET;
        foreach (sample_history[i])
            sample_history[i] = '0;
        restart_run();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG)
                write_window(row.value[WIN_W-1:0]);
            else
            begin
                known = '{row.ready, row.lo, row.hi, row.last};
                send_sample(row.value, row.last, row.kind == ROW_KNOWN, known);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_window(WIN_W'(PHASE_WIN[p]));
            weff = (PHASE_WIN[p] == 0) ? 1 :
                   ((PHASE_WIN[p] > MAX_WINDOW) ? MAX_WINDOW : PHASE_WIN[p]);
            // no sender idling here; in the pressure phase the receiver holds off
            burst_mode = (p == 2) || (p == PRESSURE_PHASE);
            if (p == PRESSURE_PHASE)
                rx_hold_req = 1'b1;
            left = PHASE_ITEMS[p];
            while (left > 0)
            begin
                // runs long enough to fill the window, a few broken short ones
                if (weff > 64)
                    seq_len = left;
                else if ($urandom_range(0, 99) < 85)
                    seq_len = $urandom_range(weff, 3 * weff + 4);
                else
                    seq_len = $urandom_range(1, weff);
                if (seq_len > left)
                    seq_len = left;
                for (int k = 0; k < seq_len; k++)
                begin
                    r = $urandom_range(0, 9);
                    case (r)
                        0:       smp = '0;
                        1:       smp = '1;
                        2:       smp = SAMPLE_W'($urandom_range(0, 15));
                        3:       smp = SAMPLE_W'($urandom_range(16'hFF00, 16'hFFFF));
                        default: smp = SAMPLE_W'($urandom_range(0, 16'hFFFF));
                    endcase
                    send_sample(smp, k == seq_len - 1, 1'b0, '0);
                end
                left -= seq_len;
            end
        end

        // drain, then watch for any stray result before the verdict
        s_axis_tvalid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_sliding_window_sum_min_max OK");
        else
            $display("tb_sliding_window_sum_min_max NOT OK");
        $finish;
    end

    // Receiver pacing: ready stretches broken by random stalls, plus one long
    // hold-off on request so that the block fills and stalls its input.
    initial
    begin : rx_pacing
        int span;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 8);
                repeat (span) @(posedge clk);
                span = pick_gap();
                if (span > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (span) @(posedge clk);
                end
            end
        end
    end

    // Compare each accepted result with the oldest pending expectation.
    always @(posedge clk)
    begin : result_check
        stats_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_stats.size() == 0)
            begin
                $error("result with no request pending");
                error_count++;
            end
            else
            begin
                want = expected_stats.pop_front();
                if (m_axis_tuser !== want.ready)
                begin
                    $error("window_ready expected %0d got %0d", want.ready, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[SUM_W-1:0] !== want.lo)
                begin
                    $error("min_sum expected %0d got %0d", want.lo, m_axis_tdata[SUM_W-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[2*SUM_W-1:SUM_W] !== want.hi)
                begin
                    $error("max_sum expected %0d got %0d", want.hi,
                           m_axis_tdata[2*SUM_W-1:SUM_W]);
                    error_count++;
                end
                if (m_axis_tdata[OUT_DATA_W-1:2*SUM_W] !== '0)
                begin
                    $error("tdata padding expected 0 got %0d",
                           m_axis_tdata[OUT_DATA_W-1:2*SUM_W]);
                    error_count++;
                end
                if (m_axis_tlast !== want.eor)
                begin
                    $error("end_of_run expected %0d got %0d", want.eor, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_sliding_window_sum_min_max NOT OK");
            $finish;
        end
    end

endmodule
